// File: hdl/nmea_rmc_pkg.sv
// ----------------------------------------------------------------------------
// NMEA RMC parser package
// Error codes, character constants and small helpers for the RMC time and
// date parser.
// ----------------------------------------------------------------------------
package nmea_rmc_pkg;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_EMPTY       = 3'd1,
        ERR_TOO_LONG    = 3'd2,
        ERR_HEADER      = 3'd3,
        ERR_NOT_VALID   = 3'd4,
        ERR_TIME        = 3'd5,
        ERR_DATE        = 3'd6,
        ERR_UNSUPPORTED = 3'd7
    } t_err;

    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_COMMA = 8'h2C;
    localparam logic [7:0] CHR_DOT   = 8'h2E;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;
    localparam logic [7:0] CHR_A     = 8'h41;

    localparam logic [3:0] FLD_HEADER = 4'd1;
    localparam logic [3:0] FLD_TIME   = 4'd2;
    localparam logic [3:0] FLD_STATUS = 4'd3;
    localparam logic [3:0] FLD_DATE   = 4'd10;
    localparam logic [3:0] FLD_LAST   = 4'd15;

    localparam logic [2:0] LEN_SIX = 3'd6;
    localparam logic [2:0] LEN_SAT = 3'd7;

    localparam logic [31:0] ADDR_RMC_REQ = 32'd0;

    // Expected header text "$GPRMC", one character per position
    function automatic logic [7:0] hdr_char(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = 8'h24;  // $
            3'd1:    ch = 8'h47;  // G
            3'd2:    ch = 8'h50;  // P
            3'd3:    ch = 8'h52;  // R
            3'd4:    ch = 8'h4D;  // M
            3'd5:    ch = 8'h43;  // C
            default: ch = CHR_NUL;
        endcase
        return ch;
    endfunction

    // Two BCD digits to binary, 0..99
    function automatic logic [6:0] bcd_pair(input logic [3:0] tens, input logic [3:0] ones);
        logic [6:0] v;
        v = ({3'b000, tens} << 3) + ({3'b000, tens} << 1) + {3'b000, ones};
        return v;
    endfunction

endpackage

// File: hdl/nmea_rmc_time_date_parser.sv
// ----------------------------------------------------------------------------
// NMEA RMC time and date parser
// Streams one RMC sentence a character at a time and reports hh:mm:ss and
// dd/mm/yy, or an error code, when the sentence ends.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready): one word per character, with
//   i_has_char marking a real character and i_last closing the sentence.
//   Output channel (o_out_valid / i_out_ready): one result word per sentence,
//   issued for the word that carries i_last.
//   Configuration: APB-style port, register rmc_requested at byte address 0.
//   Result: registered; it appears in the cycle after the last
//   word is accepted.
//   Throughput: one word per cycle. Each character updates the running field
//   state in one pass of combinational logic ahead of the state registers,
//   and the result is formed from the next-state values in the same pass.
//   Time and date digits are kept as BCD, so the split into hours, minutes
//   and seconds needs only a multiply-by-ten-and-add per pair.
//   Stall: a waiting result holds; a new word is accepted in the same cycle
//   the waiting result is taken, or whenever the output register is empty.
//   Reset: synchronous, active low. Clears the sentence state, empties the
//   output register and sets rmc_requested to 1.
// ----------------------------------------------------------------------------
module nmea_rmc_time_date_parser
    import nmea_rmc_pkg::*;
#(
    parameter int MAX_SENTENCE_LEN = 82
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_char_in,
    input  logic        i_has_char,
    input  logic        i_last,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_ok,
    output logic [2:0]  o_error_code,
    output logic [6:0]  o_hour,
    output logic [6:0]  o_minute,
    output logic [6:0]  o_second,
    output logic [6:0]  o_day,
    output logic [6:0]  o_month,
    output logic [6:0]  o_year
);

    // Character count saturates one above the limit
    localparam int CW = $clog2(MAX_SENTENCE_LEN + 2);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SENTENCE_LEN);
    localparam logic [CW-1:0] CNT_SAT = CW'(MAX_SENTENCE_LEN + 1);

    // ---------------------------------------------------------------- config
    logic r_rmc_req;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rmc_req <= 1'b1;
        end else if (cfg_wr && ({29'd0, paddr} == ADDR_RMC_REQ)) begin
            r_rmc_req <= pwdata[0];
        end
    end

    // read back rmc_requested, zero elsewhere
    assign prdata = ({29'd0, paddr} == ADDR_RMC_REQ) ? {31'd0, r_rmc_req} : 32'd0;

    // ------------------------------------------------------- sentence state
    logic [CW-1:0] r_char_count, n_char_count;
    logic [3:0]    r_field_index, n_field_index;
    logic [2:0]    r_field_len, n_field_len;
    logic          r_hdr_match, n_hdr_match;
    logic          r_status_match, n_status_match;
    logic [23:0]   r_time_bcd, n_time_bcd;
    logic [2:0]    r_time_len, n_time_len;
    logic [23:0]   r_date_bcd, n_date_bcd;
    logic [2:0]    r_date_len, n_date_len;
    logic          r_digits_stopped, n_digits_stopped;
    logic          r_dot_seen, n_dot_seen;
    logic          r_text_ended, n_text_ended;

    logic in_acc;
    logic is_digit;

    assign o_in_ready = !o_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;
    assign is_digit   = (i_char_in >= CHR_ZERO) && (i_char_in <= CHR_NINE);

    // Next state for one character. The time and date fields handle digits
    // alike: digits shift into a BCD word until a non-digit stops them.
    always_comb begin
        n_char_count     = r_char_count;
        n_field_index    = r_field_index;
        n_field_len      = r_field_len;
        n_hdr_match      = r_hdr_match;
        n_status_match   = r_status_match;
        n_time_bcd       = r_time_bcd;
        n_time_len       = r_time_len;
        n_date_bcd       = r_date_bcd;
        n_date_len       = r_date_len;
        n_digits_stopped = r_digits_stopped;
        n_dot_seen       = r_dot_seen;
        n_text_ended     = r_text_ended;

        if (in_acc && i_has_char && !r_text_ended) begin
            if (i_char_in == CHR_NUL) begin
                n_text_ended = 1'b1;
            end else begin
                if (r_char_count < CNT_SAT) begin
                    n_char_count = r_char_count + 1'b1;
                end
                if (i_char_in == CHR_COMMA) begin
                    // close the field and advance
                    if (r_field_index == FLD_HEADER && r_field_len != LEN_SIX) begin
                        n_hdr_match = 1'b0;
                    end
                    if (r_field_index < FLD_LAST) begin
                        n_field_index = r_field_index + 1'b1;
                    end
                    n_field_len      = 3'd0;
                    n_digits_stopped = 1'b0;
                    n_dot_seen       = 1'b0;
                end else begin
                    priority if (r_field_index == FLD_HEADER) begin
                        if (r_field_len >= LEN_SIX || i_char_in != hdr_char(r_field_len)) begin
                            n_hdr_match = 1'b0;
                        end
                    end else if (r_field_index == FLD_TIME) begin
                        if (!r_dot_seen) begin
                            if (i_char_in == CHR_DOT) begin
                                n_dot_seen = 1'b1;
                            end else begin
                                if (!r_digits_stopped) begin
                                    if (is_digit) begin
                                        if (r_time_len < LEN_SIX) begin
                                            n_time_bcd = {r_time_bcd[19:0], i_char_in[3:0]};
                                        end
                                    end else begin
                                        n_digits_stopped = 1'b1;
                                    end
                                end
                                if (r_time_len < LEN_SAT) begin
                                    n_time_len = r_time_len + 1'b1;
                                end
                            end
                        end
                    end else if (r_field_index == FLD_STATUS) begin
                        n_status_match = (r_field_len == 3'd0) && (i_char_in == CHR_A);
                    end else if (r_field_index == FLD_DATE) begin
                        if (!r_digits_stopped) begin
                            if (is_digit) begin
                                if (r_date_len < LEN_SIX) begin
                                    n_date_bcd = {r_date_bcd[19:0], i_char_in[3:0]};
                                end
                            end else begin
                                n_digits_stopped = 1'b1;
                            end
                        end
                        if (r_date_len < LEN_SAT) begin
                            n_date_len = r_date_len + 1'b1;
                        end
                    end else begin
                        // other fields only count length
                    end
                    if (r_field_len < LEN_SAT) begin
                        n_field_len = r_field_len + 1'b1;
                    end
                end
            end
        end
    end

    // Clear the sentence state after the last word, else advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (in_acc && i_last)) begin
            r_char_count     <= '0;
            r_field_index    <= FLD_HEADER;
            r_field_len      <= 3'd0;
            r_hdr_match      <= 1'b1;
            r_status_match   <= 1'b0;
            r_time_bcd       <= 24'd0;
            r_time_len       <= 3'd0;
            r_date_bcd       <= 24'd0;
            r_date_len       <= 3'd0;
            r_digits_stopped <= 1'b0;
            r_dot_seen       <= 1'b0;
            r_text_ended     <= 1'b0;
        end else begin
            r_char_count     <= n_char_count;
            r_field_index    <= n_field_index;
            r_field_len      <= n_field_len;
            r_hdr_match      <= n_hdr_match;
            r_status_match   <= n_status_match;
            r_time_bcd       <= n_time_bcd;
            r_time_len       <= n_time_len;
            r_date_bcd       <= n_date_bcd;
            r_date_len       <= n_date_len;
            r_digits_stopped <= n_digits_stopped;
            r_dot_seen       <= n_dot_seen;
            r_text_ended     <= n_text_ended;
        end
    end

    // ---------------------------------------------------------- result word
    logic hdr_final;
    t_err err;

    // the header field is also closed by the end of the sentence
    assign hdr_final = n_hdr_match &&
                       !(n_field_index == FLD_HEADER && n_field_len != LEN_SIX);

    always_comb begin
        priority if (!r_rmc_req) begin
            err = ERR_UNSUPPORTED;
        end else if (n_char_count == '0) begin
            err = ERR_EMPTY;
        end else if (n_char_count > CNT_MAX) begin
            err = ERR_TOO_LONG;
        end else if (!hdr_final) begin
            err = ERR_HEADER;
        end else if (!n_status_match) begin
            err = ERR_NOT_VALID;
        end else if (n_time_len != LEN_SIX || n_time_bcd == 24'd0) begin
            err = ERR_TIME;
        end else if (n_date_len != LEN_SIX || n_date_bcd == 24'd0) begin
            err = ERR_DATE;
        end else begin
            err = ERR_NONE;
        end
    end

    logic       r_out_valid;
    logic       r_ok;
    t_err       r_err;
    logic [6:0] r_hour, r_minute, r_second, r_day, r_month, r_year;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && i_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload: hold while the result waits, zero time and date on failure
    always_ff @(posedge i_clk) begin
        if (in_acc && i_last) begin
            r_ok <= (err == ERR_NONE);
            r_err <= err;
            if (err == ERR_NONE) begin
                r_hour   <= bcd_pair(n_time_bcd[23:20], n_time_bcd[19:16]);
                r_minute <= bcd_pair(n_time_bcd[15:12], n_time_bcd[11:8]);
                r_second <= bcd_pair(n_time_bcd[7:4],   n_time_bcd[3:0]);
                r_day    <= bcd_pair(n_date_bcd[23:20], n_date_bcd[19:16]);
                r_month  <= bcd_pair(n_date_bcd[15:12], n_date_bcd[11:8]);
                r_year   <= bcd_pair(n_date_bcd[7:4],   n_date_bcd[3:0]);
            end else begin
                r_hour   <= 7'd0;
                r_minute <= 7'd0;
                r_second <= 7'd0;
                r_day    <= 7'd0;
                r_month  <= 7'd0;
                r_year   <= 7'd0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_ok         = r_ok;
    assign o_error_code = r_err;
    assign o_hour       = r_hour;
    assign o_minute     = r_minute;
    assign o_second     = r_second;
    assign o_day        = r_day;
    assign o_month      = r_month;
    assign o_year       = r_year;

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// NMEA RMC time and date parser testbench
// Streams RMC sentences into the parser one character word at a time and
// checks every result word against a cycle-free prediction of the parser.
// The sentences are mostly well formed with random content, some carry one
// flaw each, and the rest is byte noise. Idling on both channels and both
// settings of rmc_requested are exercised.
// ----------------------------------------------------------------------------
module testbench;

    import nmea_rmc_pkg::*;

    localparam int SENTENCE_MAX = 82;
    localparam int RUN_LIMIT    = 1000000;

    // Header text, first character in the top byte
    localparam logic [47:0] HDR_TEXT = "$GPRMC";

    // One input word and one result word
    typedef struct {
        logic [7:0] ch;
        logic       has;
        logic       is_last;
    } t_word;

    typedef struct {
        logic       ok;
        t_err       err;
        logic [6:0] hour;
        logic [6:0] minute;
        logic [6:0] second;
        logic [6:0] day;
        logic [6:0] month;
        logic [6:0] year;
    } t_fix;

    // Which side idles and how often
    typedef enum int {
        STALL_OUT_HEAVY,    // sender idles in 7 percent of cycles, receiver 59
        STALL_IN_HEAVY,     // sender idles in 59 percent of cycles, receiver 7
        STALL_NONE
    } t_stall;

    // Flaws that a sentence may carry
    typedef enum int {
        FLAW_NONE,
        FLAW_HEADER,
        FLAW_STATUS,
        FLAW_TIME_LEN,
        FLAW_TIME_ZERO,
        FLAW_TIME_JUNK,
        FLAW_DATE_LEN,
        FLAW_DATE_ZERO,
        FLAW_DATE_JUNK,
        FLAW_FEW_FIELDS,
        FLAW_MANY_FIELDS,
        FLAW_NUL,
        FLAW_BYTE,
        FLAW_LENGTH,
        FLAW_EMPTY
    } t_flaw;

    // DUT ports, all inputs known from time zero
    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid   = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_char_in    = '0;
    logic        i_has_char   = 1'b0;
    logic        i_last       = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready  = 1'b0;
    logic        o_ok;
    logic [2:0]  o_error_code;
    logic [6:0]  o_hour;
    logic [6:0]  o_minute;
    logic [6:0]  o_second;
    logic [6:0]  o_day;
    logic [6:0]  o_month;
    logic [6:0]  o_year;

    // Stimulus and checking bookkeeping
    t_word  pending_words[$];
    t_fix   expected_fixes[$];
    int     words_queued   = 0;
    int     words_accepted = 0;
    int     mismatch_count = 0;
    logic   word_taken     = 1'b0;
    t_stall stall_mode     = STALL_OUT_HEAVY;

    // Predicted parser state
    logic        rmc_on;
    logic [6:0]  n_chars;
    logic [3:0]  fld;
    logic [2:0]  fld_len;
    logic        hdr_ok;
    logic        status_ok;
    logic [19:0] tval;
    logic [2:0]  tlen;
    logic [19:0] dval;
    logic [2:0]  dlen;
    logic        digits_halted;
    logic        dot_found;
    logic        text_done;

    nmea_rmc_time_date_parser #(
        .MAX_SENTENCE_LEN(SENTENCE_MAX)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_char_in   (i_char_in),
        .i_has_char  (i_has_char),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_ok        (o_ok),
        .o_error_code(o_error_code),
        .o_hour      (o_hour),
        .o_minute    (o_minute),
        .o_second    (o_second),
        .o_day       (o_day),
        .o_month     (o_month),
        .o_year      (o_year)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Clear everything that belongs to one sentence
    task automatic start_sentence();
        n_chars       = '0;
        fld           = FLD_HEADER;
        fld_len       = '0;
        hdr_ok        = 1'b1;
        status_ok     = 1'b0;
        tval          = '0;
        tlen          = '0;
        dval          = '0;
        dlen          = '0;
        digits_halted = 1'b0;
        dot_found     = 1'b0;
        text_done     = 1'b0;
    endtask

    // A header field that ends at any length but six is a bad header
    task automatic close_field();
        if (fld == FLD_HEADER && fld_len != LEN_SIX) begin
            hdr_ok = 1'b0;
        end
    endtask

    // Accumulate leading digits; count length regardless, saturating at 7
    task automatic take_digit(input logic [7:0] c, inout logic [19:0] value,
                              inout logic [2:0] len);
        if (!digits_halted) begin
            if (c >= CHR_ZERO && c <= CHR_NINE) begin
                if (len < LEN_SIX) begin
                    value = value * 20'd10 + {12'd0, c - CHR_ZERO};
                end
            end else begin
                digits_halted = 1'b1;
            end
        end
        if (len < LEN_SAT) begin
            len = len + 3'd1;
        end
    endtask

    // Split a six-digit value into its three decimal pairs
    task automatic split_pairs(input logic [19:0] value, output logic [6:0] hi,
                               output logic [6:0] mid, output logic [6:0] lo);
        logic [19:0] q;
        q   = value / 20'd10000;
        hi  = q[6:0];
        q   = (value / 20'd100) % 20'd100;
        mid = q[6:0];
        q   = value % 20'd100;
        lo  = q[6:0];
    endtask

    // Advance the predicted state by one accepted word; on the closing word
    // queue the result the parser must give
    task automatic parse_word(input t_word w);
        t_fix fix;
        t_err err;
        if (w.has && !text_done) begin
            if (w.ch == CHR_NUL) begin
                // a zero byte ends the text; drop everything up to the close
                text_done = 1'b1;
            end else begin
                if (n_chars < SENTENCE_MAX + 1) begin
                    n_chars = n_chars + 7'd1;
                end
                if (w.ch == CHR_COMMA) begin
                    close_field();
                    if (fld < FLD_LAST) begin
                        fld = fld + 4'd1;
                    end
                    fld_len       = '0;
                    digits_halted = 1'b0;
                    dot_found     = 1'b0;
                end else begin
                    if (fld == FLD_HEADER) begin
                        if (fld_len >= LEN_SIX) begin
                            hdr_ok = 1'b0;
                        end else if (w.ch != HDR_TEXT[47 - 8 * fld_len -: 8]) begin
                            hdr_ok = 1'b0;
                        end
                    end else if (fld == FLD_TIME) begin
                        // the time value stops at its first dot
                        if (!dot_found) begin
                            if (w.ch == CHR_DOT) begin
                                dot_found = 1'b1;
                            end else begin
                                take_digit(w.ch, tval, tlen);
                            end
                        end
                    end else if (fld == FLD_STATUS) begin
                        status_ok = (fld_len == 0 && w.ch == CHR_A);
                    end else if (fld == FLD_DATE) begin
                        take_digit(w.ch, dval, dlen);
                    end
                    if (fld_len < LEN_SAT) begin
                        fld_len = fld_len + 3'd1;
                    end
                end
            end
        end
        if (w.is_last) begin
            close_field();
            if (!rmc_on) begin
                err = ERR_UNSUPPORTED;
            end else if (n_chars == 0) begin
                err = ERR_EMPTY;
            end else if (n_chars > SENTENCE_MAX) begin
                err = ERR_TOO_LONG;
            end else if (!hdr_ok) begin
                err = ERR_HEADER;
            end else if (!status_ok) begin
                err = ERR_NOT_VALID;
            end else if (tlen != LEN_SIX || tval == 0) begin
                err = ERR_TIME;
            end else if (dlen != LEN_SIX || dval == 0) begin
                err = ERR_DATE;
            end else begin
                err = ERR_NONE;
            end
            fix.ok     = (err == ERR_NONE);
            fix.err    = err;
            fix.hour   = '0;
            fix.minute = '0;
            fix.second = '0;
            fix.day    = '0;
            fix.month  = '0;
            fix.year   = '0;
            if (fix.ok) begin
                split_pairs(tval, fix.hour, fix.minute, fix.second);
                split_pairs(dval, fix.day, fix.month, fix.year);
            end
            expected_fixes.push_back(fix);
            start_sentence();
        end
    endtask

    // ------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------

    function automatic string fix_text(input t_fix f);
        return $sformatf("ok=%0d err=%0d %0d:%0d:%0d %0d/%0d/%0d", f.ok, f.err,
                         f.hour, f.minute, f.second, f.day, f.month, f.year);
    endfunction

    // Count every mismatch, show only the first ten
    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch at %0t: %s", $realtime, what);
        end
    endtask

    // ------------------------------------------------------------------
    // Idling
    // ------------------------------------------------------------------

    function automatic int sender_gap_pct();
        case (stall_mode)
            STALL_OUT_HEAVY: return 7;
            STALL_IN_HEAVY:  return 59;
            default:         return 0;
        endcase
    endfunction

    function automatic int receiver_gap_pct();
        case (stall_mode)
            STALL_OUT_HEAVY: return 59;
            STALL_IN_HEAVY:  return 7;
            default:         return 0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: present the next pending word at the falling edge, hold it
    // until it is taken
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_word w;
        if (i_rst_n && (!i_in_valid || word_taken)) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= sender_gap_pct()) begin
                w = pending_words.pop_front();
                i_in_valid <= 1'b1;
                i_char_in  <= w.ch;
                i_has_char <= w.has;
                i_last     <= w.is_last;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall the result channel at random
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= receiver_gap_pct());
    end

    // ------------------------------------------------------------------
    // Monitor: at each rising edge check a taken result word, then feed a
    // taken input word to the prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_fix  got;
        t_fix  want;
        t_word w;
        if (!i_rst_n) begin
            word_taken <= 1'b0;
        end else begin
            // a result never belongs to the word taken at this same edge
            if (o_out_valid && i_out_ready) begin
                got.ok     = o_ok;
                got.err    = t_err'(o_error_code);
                got.hour   = o_hour;
                got.minute = o_minute;
                got.second = o_second;
                got.day    = o_day;
                got.month  = o_month;
                got.year   = o_year;
                if (expected_fixes.size() == 0) begin
                    note_mismatch({"result with nothing expected: ", fix_text(got)});
                end else begin
                    want = expected_fixes.pop_front();
                    if (got.ok !== want.ok || got.err !== want.err
                        || got.hour !== want.hour || got.minute !== want.minute
                        || got.second !== want.second || got.day !== want.day
                        || got.month !== want.month || got.year !== want.year) begin
                        note_mismatch($sformatf("expected %s, got %s",
                                                fix_text(want), fix_text(got)));
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                w.ch      = i_char_in;
                w.has     = i_has_char;
                w.is_last = i_last;
                parse_word(w);
                words_accepted++;
            end
            word_taken <= i_in_valid && o_in_ready;
        end
    end

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------

    // A setup phase, then an access phase; hold the access until pready
    task automatic apb_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic readback_rmc();
        logic [31:0] data;
        apb_access(1'b0, ADDR_RMC_REQ[2:0], '0, data);
        if (data[0] !== rmc_on) begin
            note_mismatch($sformatf("rmc_requested reads %0d, expected %0d",
                                    data[0], rmc_on));
        end
    endtask

    // Write rmc_requested with junk in the unused bits, then read it back
    task automatic program_rmc(input logic value);
        logic [31:0] data;
        logic [31:0] junk;
        junk = $urandom;
        apb_access(1'b1, ADDR_RMC_REQ[2:0], {junk[31:1], value}, data);
        rmc_on = value;
        readback_rmc();
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic queue_word(input logic [7:0] ch, input logic has, input logic is_last);
        t_word w;
        w.ch      = ch;
        w.has     = has;
        w.is_last = is_last;
        pending_words.push_back(w);
        words_queued++;
    endtask

    // Printable, no comma, no digit
    function automatic logic [7:0] junk_char();
        logic [7:0] ch;
        do begin
            ch = 8'($urandom_range(126, 33));
        end while ((ch >= CHR_ZERO && ch <= CHR_NINE) || ch == CHR_COMMA);
        return ch;
    endfunction

    function automatic string rand_digits(input int n);
        string s;
        s = "";
        for (int k = 0; k < n; k++) begin
            s = {s, $sformatf("%0d", $urandom_range(9))};
        end
        return s;
    endfunction

    // Random content of a field that nobody checks: any printable but comma
    function automatic string rand_field(input int n);
        string      s;
        logic [7:0] ch;
        s = "";
        for (int k = 0; k < n; k++) begin
            ch = 8'($urandom_range(126, 33));
            if (ch == CHR_COMMA) begin
                ch = CHR_DOT;
            end
            s = {s, $sformatf("%c", ch)};
        end
        return s;
    endfunction

    function automatic void append_text(ref logic [7:0] text[$], input string s);
        for (int k = 0; k < s.len(); k++) begin
            text.push_back(s[k]);
        end
    endfunction

    // Build one RMC sentence with random content, sometimes with one flaw
    task automatic build_fix(output logic [7:0] text[$]);
        string flds[$];
        string hdr;
        string tm;
        string st;
        string dt;
        t_flaw flaw;
        int    pos;
        int    keep;
        int    target;
        text.delete();
        flaw = FLAW_NONE;
        if ($urandom_range(99) < 45) begin
            flaw = t_flaw'($urandom_range(FLAW_EMPTY, FLAW_HEADER));
        end
        hdr = "$GPRMC";
        tm  = rand_digits(6);
        st  = "A";
        dt  = rand_digits(6);
        case (flaw)
            FLAW_HEADER: begin
                case ($urandom_range(2))
                    0: begin
                        pos = $urandom_range(5);
                        hdr[pos] = junk_char();
                    end
                    1: hdr = hdr.substr(0, $urandom_range(4));
                    default: hdr = {hdr, rand_field($urandom_range(1, 2))};
                endcase
            end
            FLAW_STATUS: begin
                case ($urandom_range(3))
                    0: st = "V";
                    1: st = "AA";
                    2: st = "";
                    default: st = "a";
                endcase
            end
            FLAW_TIME_LEN: begin
                case ($urandom_range(3))
                    0: tm = "";
                    1: tm = rand_digits(5);
                    2: tm = rand_digits(7);
                    default: tm = rand_digits($urandom_range(8, 12));
                endcase
            end
            FLAW_TIME_ZERO: tm = "000000";
            FLAW_TIME_JUNK: begin
                pos = $urandom_range(5);
                tm[pos] = junk_char();
            end
            FLAW_DATE_LEN: begin
                case ($urandom_range(3))
                    0: dt = "";
                    1: dt = rand_digits(5);
                    2: dt = rand_digits(7);
                    default: dt = rand_digits($urandom_range(8, 12));
                endcase
            end
            FLAW_DATE_ZERO: dt = "000000";
            FLAW_DATE_JUNK: begin
                pos = $urandom_range(5);
                dt[pos] = junk_char();
            end
            default: ;
        endcase
        // a fraction after the dot must not count toward the time length
        if ($urandom_range(1)) begin
            tm = {tm, ".", rand_digits($urandom_range(3))};
        end
        flds.push_back(hdr);
        flds.push_back(tm);
        flds.push_back(st);
        repeat (6) flds.push_back(rand_field($urandom_range(4)));
        flds.push_back(dt);
        repeat ($urandom_range(2)) flds.push_back(rand_field($urandom_range(3)));
        if (flaw == FLAW_FEW_FIELDS) begin
            keep = $urandom_range(1, 9);
            while (flds.size() > keep) flds.pop_back();
        end else if (flaw == FLAW_MANY_FIELDS) begin
            // push to field fifteen or well past it
            repeat ($urandom_range(5, 12)) flds.push_back(rand_field($urandom_range(2)));
        end
        foreach (flds[i]) begin
            if (i > 0) begin
                text.push_back(CHR_COMMA);
            end
            append_text(text, flds[i]);
        end
        case (flaw)
            FLAW_NUL: begin
                pos = $urandom_range(text.size());
                text.insert(pos, CHR_NUL);
            end
            FLAW_BYTE: begin
                pos = $urandom_range(text.size() - 1);
                text[pos] = 8'($urandom_range(255));
            end
            FLAW_LENGTH: begin
                // hit the limit exactly, one past it, or far past it
                case ($urandom_range(2))
                    0: target = SENTENCE_MAX;
                    1: target = SENTENCE_MAX + 1;
                    default: target = $urandom_range(SENTENCE_MAX + 2, 140);
                endcase
                if (text.size() < target) begin
                    text.push_back(CHR_COMMA);
                    while (text.size() < target) begin
                        text.push_back(CHR_ZERO + 8'($urandom_range(9)));
                    end
                end
            end
            FLAW_EMPTY: text.delete();
            default: ;
        endcase
    endtask

    // Queue a sentence as words: scatter empty words in between, and close
    // either on the final character or with a word of its own
    task automatic queue_sentence(input logic [7:0] text[$]);
        logic close_on_char;
        close_on_char = (text.size() != 0) && ($urandom_range(1) == 1);
        foreach (text[k]) begin
            if ($urandom_range(99) < 5) begin
                queue_word(8'($urandom_range(255)), 1'b0, 1'b0);
            end
            queue_word(text[k], 1'b1, close_on_char && (k == text.size() - 1));
        end
        if (!close_on_char) begin
            if ($urandom_range(99) < 20) begin
                queue_word(CHR_NUL, 1'b1, 1'b1);
            end else begin
                queue_word(8'($urandom_range(255)), 1'b0, 1'b1);
            end
        end
    endtask

    // Wait until every word is taken and every result checked, then let the
    // parser settle before touching its register
    task automatic wait_drained();
        do @(negedge i_clk);
        while (words_accepted != words_queued || expected_fixes.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // Mostly sentences with random content, the rest byte noise
    task automatic run_phase(input int min_words, input int min_sentences);
        logic [7:0] text[$];
        int         first;
        int         n;
        @(posedge i_clk);
        first = words_queued;
        n     = 0;
        while (words_queued - first < min_words || n < min_sentences) begin
            if ($urandom_range(99) < 85) begin
                build_fix(text);
            end else begin
                text.delete();
                repeat ($urandom_range(40)) text.push_back(8'($urandom_range(255)));
            end
            queue_sentence(text);
            n++;
        end
        wait_drained();
    endtask

    task automatic set_stall(input t_stall mode);
        @(posedge i_clk);
        stall_mode = mode;
    endtask

    initial begin
        logic [7:0] text[$];
        rmc_on = 1'b1;
        start_sentence();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset value of the register
        readback_rmc();

        // directed: largest digit values, an empty sentence, a leading zero byte
        @(posedge i_clk);
        text.delete();
        append_text(text, "$GPRMC,999999,A,,,,,,,999999");
        queue_sentence(text);
        queue_word(8'hFF, 1'b0, 1'b1);
        queue_word(CHR_NUL, 1'b1, 1'b1);
        wait_drained();

        run_phase(220, 4);
        program_rmc(1'b0);
        run_phase(30, 1);

        set_stall(STALL_IN_HEAVY);
        program_rmc(1'b1);
        run_phase(220, 4);
        program_rmc(1'b0);
        run_phase(30, 1);

        set_stall(STALL_NONE);
        program_rmc(1'b1);
        run_phase(180, 4);

        // hold a while longer to catch a stray result
        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0 && expected_fixes.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #RUN_LIMIT;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// File: filelist.f
hdl/nmea_rmc_pkg.sv
hdl/nmea_rmc_time_date_parser.sv
tb/testbench.sv
